// ===== rtl/core/eaic_pkg.sv =====
// Shared types and constants for the Ethernet ARP/ICMP receive classifier.
// No dependencies; compiled first.
`default_nettype none

package eaic_pkg;

  localparam int unsigned CNT_W = 6;
  localparam logic [CNT_W-1:0] CNT_MAX = 6'd63;

  // Configuration register indexes
  localparam logic REG_STATION_MAC = 1'b0;
  localparam logic REG_STATION_IP  = 1'b1;

  // Verdict codes
  localparam logic [2:0] VERDICT_IGNORE     = 3'd0;
  localparam logic [2:0] VERDICT_ARP_REQ    = 3'd1;
  localparam logic [2:0] VERDICT_ECHO_REQ   = 3'd2;
  localparam logic [2:0] VERDICT_ECHO_REPLY = 3'd3;
  localparam logic [2:0] VERDICT_SHORT      = 3'd4;

  // Protocol values
  localparam logic [15:0] ETYPE_ARP     = 16'h0806;
  localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
  localparam logic [15:0] ARP_OP_REQ    = 16'h0001;
  localparam logic [7:0]  IP_PROTO_ICMP = 8'd1;
  localparam logic [7:0]  ICMP_ECHO_REQ = 8'd8;
  localparam logic [7:0]  ICMP_ECHO_REP = 8'd0;
  localparam logic [7:0]  BCAST_BYTE    = 8'hFF;

  // Byte offsets within the frame
  localparam logic [CNT_W-1:0] OFS_MAC_END    = 6'd6;
  localparam logic [CNT_W-1:0] OFS_ETYPE_HI   = 6'd12;
  localparam logic [CNT_W-1:0] OFS_ETYPE_LO   = 6'd13;
  localparam logic [CNT_W-1:0] OFS_ARP_OP_HI  = 6'd20;
  localparam logic [CNT_W-1:0] OFS_ARP_OP_LO  = 6'd21;
  localparam logic [CNT_W-1:0] OFS_IP_PROTO   = 6'd23;
  localparam logic [CNT_W-1:0] OFS_IP_DST_LO  = 6'd30;
  localparam logic [CNT_W-1:0] OFS_IP_DST_HI  = 6'd33;
  localparam logic [CNT_W-1:0] OFS_ICMP_TYPE  = 6'd34;
  localparam logic [CNT_W-1:0] OFS_ARP_TPA_LO = 6'd38;
  localparam logic [CNT_W-1:0] OFS_ARP_TPA_HI = 6'd41;

  // Minimum lengths
  localparam logic [CNT_W-1:0] LEN_ETH_HDR = 6'd14;
  localparam logic [CNT_W-1:0] LEN_IP_HDR  = 6'd34;
  localparam logic [CNT_W-1:0] LEN_FULL    = 6'd42;

  typedef struct packed {
    logic        dest_all_ones;
    logic        dest_is_station;
    logic [15:0] ether_type;
    logic [15:0] arp_opcode;
    logic        arp_target_matches;
    logic        ip_dest_matches;
    logic [7:0]  ip_protocol;
    logic [7:0]  icmp_type;
  } frame_state_t;

  localparam frame_state_t FRAME_CLEAR = '{
    dest_all_ones:      1'b1,
    dest_is_station:    1'b1,
    ether_type:         16'h0000,
    arp_opcode:         16'h0000,
    arp_target_matches: 1'b1,
    ip_dest_matches:    1'b1,
    ip_protocol:        8'h00,
    icmp_type:          8'h00
  };

  // Byte k of the station IP, first wire byte at k = 0
  function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0:    b = ip[31:24];
      2'd1:    b = ip[23:16];
      2'd2:    b = ip[15:8];
      default: b = ip[7:0];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/eaic_if.sv =====
// Valid/ready channel interfaces for the classifier: byte input and verdict output.
// No dependencies.
`default_nettype none

interface eaic_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface eaic_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/eaic_decide.sv =====
// End-of-frame decision: maps captured header state and frame length to a verdict.
// Depends on eaic_pkg.
`default_nettype none

module eaic_decide (
  input  eaic_pkg::frame_state_t       st,
  input  logic [eaic_pkg::CNT_W-1:0]   len,
  output logic [2:0]                   verdict
);
  import eaic_pkg::*;

  always_comb begin
    verdict = VERDICT_IGNORE;
    if (len < LEN_ETH_HDR) begin
      verdict = VERDICT_SHORT;
    end else if (!st.dest_all_ones && !st.dest_is_station) begin
      verdict = VERDICT_IGNORE;
    end else if (st.ether_type == ETYPE_ARP) begin
      if (len < LEN_FULL) begin
        verdict = VERDICT_SHORT;
      end else if (st.arp_opcode == ARP_OP_REQ && st.arp_target_matches) begin
        verdict = VERDICT_ARP_REQ;
      end
    end else if (st.ether_type == ETYPE_IPV4) begin
      if (len < LEN_IP_HDR) begin
        verdict = VERDICT_SHORT;
      end else if (st.ip_dest_matches && st.ip_protocol == IP_PROTO_ICMP) begin
        if (len < LEN_FULL) begin
          verdict = VERDICT_SHORT;
        end else if (st.icmp_type == ICMP_ECHO_REQ) begin
          verdict = VERDICT_ECHO_REQ;
        end else if (st.icmp_type == ICMP_ECHO_REP) begin
          verdict = VERDICT_ECHO_REPLY;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ethernet_arp_icmp_classifier.sv =====
// Top level of the Ethernet ARP/ICMP receive classifier.
// Depends on eaic_pkg, eaic_if (eaic_in_if, eaic_out_if) and eaic_decide.
//
// Usage:
//  - in_chan carries one frame byte per beat (data_byte) with last_byte set on
//    the final byte. Beats may arrive every cycle.
//  - out_chan carries one verdict beat per frame, produced from the beat that
//    carried last_byte: 0 ignore, 1 ARP request for us, 2 ICMP echo request,
//    3 ICMP echo reply, 4 frame too short.
//  - Latency: the verdict is valid the cycle after the last byte is accepted.
//  - Throughput: one byte per cycle when not stalled; the per-byte work is a byte
//    compare and a 6-bit counter step ahead of header-state and verdict registers.
//  - Stall: the verdict register holds until out_chan.ready; a new byte is taken
//    while it is empty or being drained in the same cycle, so a stalled receiver
//    back-pressures the byte stream only while a verdict is waiting.
//  - cfg_we/cfg_index/cfg_data write station MAC (index 0) or station IP
//    (index 1); write only between frames.
//  - Reset (rst_n low, synchronous) clears the registers, the byte counter,
//    the header state and the pending verdict.
//  - Frames longer than 63 bytes: the counter saturates and later bytes are
//    not examined.
`default_nettype none

module ethernet_arp_icmp_classifier (
  input  wire logic          clk,
  input  wire logic          rst_n,
  eaic_in_if.sink            in_chan,
  eaic_out_if.source         out_chan,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [47:0]   cfg_data
);
  import eaic_pkg::*;

  logic [47:0]      mac_r;
  logic [31:0]      ip_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  frame_state_t     st_r, st_nxt;
  logic             out_valid_r;
  logic [2:0]       out_verdict_r;
  logic [2:0]       verdict_nxt;
  logic [7:0]       b;
  logic [7:0]       mac_byte;
  logic [7:0]       ipb;
  logic             acc;

  assign acc            = in_chan.valid && in_chan.ready;
  assign in_chan.ready  = !out_valid_r || out_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.verdict = out_verdict_r;
  assign b              = in_chan.data_byte;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac_r <= '0;
      ip_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STATION_MAC: mac_r <= cfg_data;
        REG_STATION_IP:  ip_r  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Expected destination MAC byte at this offset
  always_comb begin
    case (cnt_r[2:0])
      3'd0:    mac_byte = mac_r[47:40];
      3'd1:    mac_byte = mac_r[39:32];
      3'd2:    mac_byte = mac_r[31:24];
      3'd3:    mac_byte = mac_r[23:16];
      3'd4:    mac_byte = mac_r[15:8];
      3'd5:    mac_byte = mac_r[7:0];
      default: mac_byte = 8'h00;
    endcase
  end

  // IP field offsets 30..33 and 38..41 both start at 2 mod 4
  assign ipb = ip_byte(ip_r, cnt_r[1:0] - 2'd2);

  // Per-byte header capture
  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    if (cnt_r != CNT_MAX) begin
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r < OFS_MAC_END) begin
        if (b != BCAST_BYTE) st_nxt.dest_all_ones = 1'b0;
        if (b != mac_byte)   st_nxt.dest_is_station = 1'b0;
      end else if (cnt_r == OFS_ETYPE_HI) begin
        st_nxt.ether_type[15:8] = b;
      end else if (cnt_r == OFS_ETYPE_LO) begin
        st_nxt.ether_type[7:0] = b;
      end
      // ARP view
      if (cnt_r == OFS_ARP_OP_HI) begin
        st_nxt.arp_opcode[15:8] = b;
      end else if (cnt_r == OFS_ARP_OP_LO) begin
        st_nxt.arp_opcode[7:0] = b;
      end else if (cnt_r >= OFS_ARP_TPA_LO && cnt_r <= OFS_ARP_TPA_HI) begin
        if (b != ipb) st_nxt.arp_target_matches = 1'b0;
      end
      // IPv4 / ICMP view
      if (cnt_r == OFS_IP_PROTO) begin
        st_nxt.ip_protocol = b;
      end else if (cnt_r >= OFS_IP_DST_LO && cnt_r <= OFS_IP_DST_HI) begin
        if (b != ipb) st_nxt.ip_dest_matches = 1'b0;
      end else if (cnt_r == OFS_ICMP_TYPE) begin
        st_nxt.icmp_type = b;
      end
    end
  end

  // Decision sees the state including the current (last) byte
  eaic_decide u_decide (
    .st      (st_nxt),
    .len     (cnt_nxt),
    .verdict (verdict_nxt)
  );

  // Frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      st_r  <= FRAME_CLEAR;
    end else if (acc) begin
      if (in_chan.last_byte) begin
        cnt_r <= '0;
        st_r  <= FRAME_CLEAR;
      end else begin
        cnt_r <= cnt_nxt;
        st_r  <= st_nxt;
      end
    end
  end

  // Verdict register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc && in_chan.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_chan.last_byte) begin
      out_verdict_r <= verdict_nxt;
    end
  end

  // A new verdict only comes from a last-byte beat
  a_rose_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(acc && in_chan.last_byte))
    else $error("verdict appeared without a last-byte beat");

  // A pending verdict is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |-> !acc)
    else $error("byte accepted while verdict stalled");

  // Counter restarts after each frame
  a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_chan.last_byte |=> cnt_r == '0 && st_r == FRAME_CLEAR)
    else $error("frame state not cleared after last byte");

  // Counter steps by one per middle byte until saturation
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !in_chan.last_byte && cnt_r != CNT_MAX |=> cnt_r == $past(cnt_r) + 6'd1)
    else $error("byte counter did not advance");

  // Verdict code within the defined range
  a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_verdict_r <= VERDICT_SHORT)
    else $error("verdict code out of range");

endmodule

`default_nettype wire

// ===== verif/verdict_checker.sv =====
`timescale 1ns / 100ps
// Checker for the ARP/ICMP classifier: watches both channels and the config port.
// Tracks the header state per frame and compares each verdict beat in order.
// Depends on eaic_pkg and the eaic_in_if / eaic_out_if interfaces.

module verdict_checker (
  input  logic        clk,
  input  logic        rst_n,
  eaic_in_if          in_mon,
  eaic_out_if         out_mon,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  import eaic_pkg::*;

  logic [47:0]      own_mac;
  logic [31:0]      own_ip;
  logic [CNT_W-1:0] seen_bytes;
  frame_state_t     hdr;
  logic [2:0]       verdict_q[$];
  logic [2:0]       want;

  // Fold one byte at frame offset seen_bytes into the header state.
  task automatic absorb_byte(input logic [7:0] b);
    int idx;
    idx = int'(seen_bytes);
    if (idx < int'(OFS_MAC_END)) begin
      if (b != BCAST_BYTE) hdr.dest_all_ones = 1'b0;
      if (b != own_mac[47 - 8*idx -: 8]) hdr.dest_is_station = 1'b0;
    end else if (idx == int'(OFS_ETYPE_HI)) begin
      hdr.ether_type[15:8] = b;
    end else if (idx == int'(OFS_ETYPE_LO)) begin
      hdr.ether_type[7:0] = b;
    end
    if (idx == int'(OFS_ARP_OP_HI)) begin
      hdr.arp_opcode[15:8] = b;
    end else if (idx == int'(OFS_ARP_OP_LO)) begin
      hdr.arp_opcode[7:0] = b;
    end else if (idx >= int'(OFS_ARP_TPA_LO) && idx <= int'(OFS_ARP_TPA_HI)) begin
      if (b != own_ip[31 - 8*(idx - int'(OFS_ARP_TPA_LO)) -: 8])
        hdr.arp_target_matches = 1'b0;
    end
    if (idx == int'(OFS_IP_PROTO)) begin
      hdr.ip_protocol = b;
    end else if (idx >= int'(OFS_IP_DST_LO) && idx <= int'(OFS_IP_DST_HI)) begin
      if (b != own_ip[31 - 8*(idx - int'(OFS_IP_DST_LO)) -: 8])
        hdr.ip_dest_matches = 1'b0;
    end else if (idx == int'(OFS_ICMP_TYPE)) begin
      hdr.icmp_type = b;
    end
  endtask

  // Verdict for a finished frame of saturated length len.
  function automatic logic [2:0] classify_frame(input int len);
    if (len < int'(LEN_ETH_HDR)) return VERDICT_SHORT;
    if (!hdr.dest_all_ones && !hdr.dest_is_station) return VERDICT_IGNORE;
    if (hdr.ether_type == ETYPE_ARP) begin
      if (len < int'(LEN_FULL)) return VERDICT_SHORT;
      if (hdr.arp_opcode == ARP_OP_REQ && hdr.arp_target_matches) return VERDICT_ARP_REQ;
      return VERDICT_IGNORE;
    end
    if (hdr.ether_type == ETYPE_IPV4) begin
      if (len < int'(LEN_IP_HDR)) return VERDICT_SHORT;
      if (!hdr.ip_dest_matches) return VERDICT_IGNORE;
      if (hdr.ip_protocol == IP_PROTO_ICMP) begin
        if (len < int'(LEN_FULL)) return VERDICT_SHORT;
        if (hdr.icmp_type == ICMP_ECHO_REQ) return VERDICT_ECHO_REQ;
        if (hdr.icmp_type == ICMP_ECHO_REP) return VERDICT_ECHO_REPLY;
      end
    end
    return VERDICT_IGNORE;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      own_mac    = '0;
      own_ip     = '0;
      seen_bytes = '0;
      hdr        = FRAME_CLEAR;
      fail_count = 0;
      verdict_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (verdict_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: verdict beat %0d with nothing outstanding", $realtime,
                     out_mon.verdict);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (out_mon.verdict !== want) begin
            if (fail_count < 10)
              $display("%0t: verdict mismatch: expected %0d, got %0d", $realtime,
                       want, out_mon.verdict);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (seen_bytes < CNT_MAX) begin
          absorb_byte(in_mon.data_byte);
          seen_bytes = seen_bytes + 1'b1;
        end
        if (in_mon.last_byte) begin
          verdict_q.push_back(classify_frame(int'(seen_bytes)));
          seen_bytes = '0;
          hdr        = FRAME_CLEAR;
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_STATION_MAC) own_mac = cfg_data;
        else own_ip = cfg_data[31:0];
      end
    end
    pending = verdict_q.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Top of the classifier regression: clock, reset, frame stimulus and verdict.
// Depends on eaic_pkg, eaic_if, the classifier RTL and verdict_checker.

module testbench;
  import eaic_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_FRAME    = 80;   // longer than the 63-byte counter on purpose
  localparam int PHASE_BYTES  = 60;
  localparam int PHASE_FRAMES = 1;
  localparam int NUM_PHASES   = 6;
  localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [47:0] cfg_data;
  int          fail_count;
  int          pending;
  int          cycles = 0;

  // Station addresses as last programmed; frames are aimed at (or near) them.
  logic [47:0] cur_mac;
  logic [31:0] cur_ip;
  logic [7:0]  frm [0:MAX_FRAME-1];

  eaic_in_if  in_bus ();
  eaic_out_if out_bus ();

  ethernet_arp_icmp_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_bus),
    .out_chan  (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  verdict_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case a beat or a verdict never shows up.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Idle length: mostly none, some short, a few long.
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 24);
  endfunction

  // Receiver back-pressure: stall periods alternate with ready runs.
  initial begin
    int hold;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = gap_cycles();
      repeat (hold) @(negedge clk) out_bus.ready <= 1'b0;
      hold = $urandom_range(1, 12);
      repeat (hold) @(negedge clk) out_bus.ready <= 1'b1;
    end
  end

  // Program both registers back to back; upper cfg_data bits of the IP write
  // carry junk to show the register keeps only its own width.
  task automatic set_station(input logic [47:0] mac, input logic [31:0] ip);
    cfg_we    <= 1'b1;
    cfg_index <= REG_STATION_MAC;
    cfg_data  <= mac;
    @(negedge clk);
    cfg_index <= REG_STATION_IP;
    cfg_data  <= {16'($urandom), ip};
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_mac = mac;
    cur_ip  = ip;
    @(negedge clk);
  endtask

  // One beat; called at a falling edge, returns at the falling edge after the
  // beat was taken. valid is left high so back-to-back beats need no toggle.
  task automatic push_beat(input logic [7:0] b, input logic l, input int gap);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.last_byte <= l;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    @(negedge clk);
  endtask

  // Lay out a frame with the given header fields over random or constant
  // filler and stream it. Both the ARP and IPv4 views are filled in; only the
  // one picked by the EtherType matters to the block.
  task automatic send_frame(input int len, input logic [47:0] dmac,
                            input logic [15:0] etype, input logic [15:0] arp_op,
                            input logic [31:0] tpa, input logic [7:0] proto,
                            input logic [31:0] dip, input logic [7:0] icmp_t,
                            input bit rand_fill, input logic [7:0] fill);
    bit burst;
    for (int i = 0; i < MAX_FRAME; i++) frm[i] = rand_fill ? 8'($urandom) : fill;
    for (int i = 0; i < 6; i++) frm[i] = dmac[47 - 8*i -: 8];
    {frm[12], frm[13]} = etype;
    {frm[20], frm[21]} = arp_op;
    frm[23] = proto;
    {frm[30], frm[31], frm[32], frm[33]} = dip;
    frm[34] = icmp_t;
    {frm[38], frm[39], frm[40], frm[41]} = tpa;
    burst = ($urandom_range(0, 3) == 0);  // some frames go without any gap
    for (int i = 0; i < len; i++)
      push_beat(frm[i], i == len - 1, burst ? 0 : gap_cycles());
  endtask

  // Let every verdict drain, then wait so the block is idle for config.
  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [31:0] flip32(input logic [31:0] x);
    return x ^ (32'h1 << $urandom_range(0, 31));
  endfunction

  // Destination: mostly ours or broadcast, some near misses and noise.
  function automatic logic [47:0] pick_dest();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return cur_mac;
    if (r < 75) return BCAST_MAC;
    if (r < 90) return cur_mac ^ (48'h1 << $urandom_range(0, 47));
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Random traffic under one station setting. Mostly well-formed ARP and
  // ICMP frames with random payload, the rest broken headers and noise.
  task automatic run_random_phase(input logic [47:0] mac, input logic [31:0] ip);
    int len, r, bytes_sent, frames_sent;
    logic [15:0] etype, arp_op;
    logic [31:0] tpa, dip;
    logic [7:0]  proto, icmp_t;
    set_station(mac, ip);
    bytes_sent  = 0;
    frames_sent = 0;
    while (bytes_sent < PHASE_BYTES || frames_sent < PHASE_FRAMES) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(int'(LEN_FULL), 64);
      else if (r < 85) len = $urandom_range(65, MAX_FRAME);
      else len = $urandom_range(1, int'(LEN_FULL) - 1);
      r = $urandom_range(0, 99);
      if (r < 40) etype = ETYPE_ARP;
      else if (r < 85) etype = ETYPE_IPV4;
      else if (r < 92) etype = 16'($urandom);
      else etype = (r[0] ? ETYPE_ARP : ETYPE_IPV4) ^ (16'h1 << $urandom_range(0, 15));
      r = $urandom_range(0, 9);
      if (r < 8) arp_op = ARP_OP_REQ;
      else if (r == 8) arp_op = 16'h0002;
      else arp_op = ARP_OP_REQ ^ (16'h1 << $urandom_range(1, 15));
      tpa    = ($urandom_range(0, 4) != 0) ? cur_ip : flip32(cur_ip);
      dip    = ($urandom_range(0, 4) != 0) ? cur_ip : flip32(cur_ip);
      proto  = ($urandom_range(0, 4) != 0) ? IP_PROTO_ICMP : 8'($urandom);
      r = $urandom_range(0, 9);
      if (r < 4) icmp_t = ICMP_ECHO_REQ;
      else if (r < 8) icmp_t = ICMP_ECHO_REP;
      else icmp_t = 8'($urandom);
      send_frame(len, pick_dest(), etype, arp_op, tpa, proto, dip, icmp_t, 1'b1, 8'h00);
      bytes_sent  += len;
      frames_sent += 1;
    end
    drain();
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = REG_STATION_MAC;
    cfg_data         = '0;
    in_bus.valid     = 1'b0;
    in_bus.data_byte = '0;
    in_bus.last_byte = 1'b0;
    cur_mac          = '0;
    cur_ip           = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames: every verdict, each length threshold on both sides,
    // all-zero / all-ones filler, and a frame past the counter's saturation.
    set_station(48'h02_00_5E_10_20_30, 32'hC0_A8_01_05);
    // single byte, and one byte short of an Ethernet header
    send_frame(1, cur_mac, ETYPE_ARP, ARP_OP_REQ, cur_ip, IP_PROTO_ICMP, cur_ip,
               ICMP_ECHO_REQ, 1'b0, 8'h00);
    send_frame(13, cur_mac, ETYPE_ARP, ARP_OP_REQ, cur_ip, IP_PROTO_ICMP, cur_ip,
               ICMP_ECHO_REQ, 1'b1, 8'h00);
    // bare header, unknown EtherType
    send_frame(14, BCAST_MAC, 16'h1234, ARP_OP_REQ, cur_ip, IP_PROTO_ICMP, cur_ip,
               ICMP_ECHO_REQ, 1'b1, 8'h00);
    // bare header with ARP type: too short for ARP
    send_frame(14, BCAST_MAC, ETYPE_ARP, ARP_OP_REQ, cur_ip, IP_PROTO_ICMP, cur_ip,
               ICMP_ECHO_REQ, 1'b1, 8'h00);
    // ARP: minimal request, one byte short, reply opcode, wrong target
    send_frame(42, BCAST_MAC, ETYPE_ARP, ARP_OP_REQ, cur_ip, IP_PROTO_ICMP, cur_ip,
               ICMP_ECHO_REQ, 1'b0, 8'hFF);
    send_frame(41, BCAST_MAC, ETYPE_ARP, ARP_OP_REQ, cur_ip, IP_PROTO_ICMP, cur_ip,
               ICMP_ECHO_REQ, 1'b1, 8'h00);
    send_frame(42, cur_mac, ETYPE_ARP, 16'h0002, cur_ip, IP_PROTO_ICMP, cur_ip,
               ICMP_ECHO_REQ, 1'b1, 8'h00);
    send_frame(42, cur_mac, ETYPE_ARP, ARP_OP_REQ, ~cur_ip, IP_PROTO_ICMP, cur_ip,
               ICMP_ECHO_REQ, 1'b1, 8'h00);
    // ARP request to a MAC that is one bit off ours
    send_frame(42, cur_mac ^ (48'h1 << 40), ETYPE_ARP, ARP_OP_REQ, cur_ip, IP_PROTO_ICMP,
               cur_ip, ICMP_ECHO_REQ, 1'b1, 8'h00);
    // IPv4: short of the IP header, non-ICMP, ICMP cut short
    send_frame(33, cur_mac, ETYPE_IPV4, ARP_OP_REQ, cur_ip, IP_PROTO_ICMP, cur_ip,
               ICMP_ECHO_REQ, 1'b1, 8'h00);
    send_frame(34, cur_mac, ETYPE_IPV4, ARP_OP_REQ, cur_ip, 8'd6, cur_ip,
               ICMP_ECHO_REQ, 1'b1, 8'h00);
    send_frame(41, cur_mac, ETYPE_IPV4, ARP_OP_REQ, cur_ip, IP_PROTO_ICMP, cur_ip,
               ICMP_ECHO_REQ, 1'b1, 8'h00);
    // ICMP echo request / reply / other type, wrong destination IP
    send_frame(42, cur_mac, ETYPE_IPV4, ARP_OP_REQ, cur_ip, IP_PROTO_ICMP, cur_ip,
               ICMP_ECHO_REQ, 1'b0, 8'h00);
    send_frame(42, BCAST_MAC, ETYPE_IPV4, ARP_OP_REQ, cur_ip, IP_PROTO_ICMP, cur_ip,
               ICMP_ECHO_REP, 1'b0, 8'hFF);
    send_frame(60, cur_mac, ETYPE_IPV4, ARP_OP_REQ, cur_ip, IP_PROTO_ICMP, cur_ip,
               8'd3, 1'b1, 8'h00);
    send_frame(42, cur_mac, ETYPE_IPV4, ARP_OP_REQ, cur_ip, IP_PROTO_ICMP, cur_ip ^ 32'h1,
               ICMP_ECHO_REQ, 1'b1, 8'h00);
    // EtherType one bit away from IPv4
    send_frame(42, cur_mac, 16'h0801, ARP_OP_REQ, cur_ip, IP_PROTO_ICMP, cur_ip,
               ICMP_ECHO_REQ, 1'b1, 8'h00);
    // around and beyond counter saturation
    send_frame(63, cur_mac, ETYPE_IPV4, ARP_OP_REQ, cur_ip, IP_PROTO_ICMP, cur_ip,
               ICMP_ECHO_REP, 1'b1, 8'h00);
    send_frame(64, cur_mac, ETYPE_IPV4, ARP_OP_REQ, cur_ip, IP_PROTO_ICMP, cur_ip,
               ICMP_ECHO_REQ, 1'b1, 8'h00);
    send_frame(MAX_FRAME, BCAST_MAC, ETYPE_ARP, ARP_OP_REQ, cur_ip, IP_PROTO_ICMP, cur_ip,
               ICMP_ECHO_REQ, 1'b0, 8'h00);
    drain();

    // Random phases, each under its own station setting, extremes included.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       run_random_phase('0, '0);
        1:       run_random_phase(BCAST_MAC, 32'hFFFF_FFFF);
        2:       run_random_phase({16'($urandom), 32'($urandom)}, '0);
        3:       run_random_phase('0, 32'hFFFF_FFFF);
        default: run_random_phase({16'($urandom), 32'($urandom)}, 32'($urandom));
      endcase
    end

    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/eaic_pkg.sv
rtl/core/eaic_if.sv
rtl/core/eaic_decide.sv
rtl/core/ethernet_arp_icmp_classifier.sv
verif/verdict_checker.sv
verif/testbench.sv
